FILE: hw/rtl/iprc_pkg.sv
// ----------------------------------------------------------------------------
// iprc_pkg - shared types and constants of the incremental PI regulator
// Holds the sequencer state codes, the command bundle from the controller to
// the datapath, register indexes and clamp codes.
// ----------------------------------------------------------------------------
package iprc_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TI      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd3;

	// reset values of the configuration registers
	localparam logic [15:0] KP_RESET      = 16'd256;
	localparam logic [15:0] TI_RESET      = 16'd256;
	localparam logic [15:0] OUT_MIN_RESET = 16'h8000;
	localparam logic [15:0] OUT_MAX_RESET = 16'h7FFF;

	// clamp codes
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_LOW  = 2'd1;
	localparam logic [1:0] CLAMP_HIGH = 2'd2;

	// n/10 == (n * RECIP10) >> RECIP10_SHIFT for every n below 2^32
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int unsigned RECIP10_SHIFT = 35;

	// 48-bit quotient, two bits per divider cycle
	localparam int unsigned DIV_BITS   = 48;
	localparam int unsigned DIV_RADIX  = 2;
	localparam int unsigned DIV_STEPS  = DIV_BITS / DIV_RADIX;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_SCALE  = 11'b000_0000_0010,
		ST_ERR    = 11'b000_0000_0100,
		ST_MUL1   = 11'b000_0000_1000,
		ST_MUL2   = 11'b000_0001_0000,
		ST_ACC    = 11'b000_0010_0000,
		ST_DSET   = 11'b000_0100_0000,
		ST_DIV    = 11'b000_1000_0000,
		ST_CLAMP  = 11'b001_0000_0000,
		ST_COMMIT = 11'b010_0000_0000,
		ST_FINISH = 11'b100_0000_0000
	} iprc_state_t;

	typedef struct packed {
		logic load_in;
		logic scale;
		logic err;
		logic mul1;
		logic mul2;
		logic acc;
		logic dset;
		logic div_step;
		logic clamp;
		logic commit;
		logic out_load;
	} iprc_cmd_t;

endpackage

FILE: hw/rtl/iprc_ctrl.sv
// ----------------------------------------------------------------------------
// iprc_ctrl - sequencer of the incremental PI regulator
// Steps one sample through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module iprc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output iprc_pkg::iprc_cmd_t  cmd
);

	iprc_pkg::iprc_state_t             state_q, state_d;
	logic [iprc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                              out_valid_q;
	logic                              div_last;
	logic                              deliver;

	assign in_ready  = (state_q == iprc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign div_last  = (cnt_q == iprc_pkg::DIV_CNT_W'(iprc_pkg::DIV_STEPS - 1));
	// result may enter the output register once it is empty or being taken
	assign deliver   = (state_q == iprc_pkg::ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			iprc_pkg::ST_IDLE:   if (in_valid) state_d = iprc_pkg::ST_SCALE;
			iprc_pkg::ST_SCALE:  state_d = iprc_pkg::ST_ERR;
			iprc_pkg::ST_ERR:    state_d = iprc_pkg::ST_MUL1;
			iprc_pkg::ST_MUL1:   state_d = iprc_pkg::ST_MUL2;
			iprc_pkg::ST_MUL2:   state_d = iprc_pkg::ST_ACC;
			iprc_pkg::ST_ACC:    state_d = iprc_pkg::ST_DSET;
			iprc_pkg::ST_DSET:   state_d = iprc_pkg::ST_DIV;
			iprc_pkg::ST_DIV:    if (div_last) state_d = iprc_pkg::ST_CLAMP;
			iprc_pkg::ST_CLAMP:  state_d = iprc_pkg::ST_COMMIT;
			iprc_pkg::ST_COMMIT: state_d = iprc_pkg::ST_FINISH;
			iprc_pkg::ST_FINISH: if (deliver) state_d = iprc_pkg::ST_IDLE;
			default:             state_d = iprc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_ready && in_valid;
		cmd.scale    = (state_q == iprc_pkg::ST_SCALE);
		cmd.err      = (state_q == iprc_pkg::ST_ERR);
		cmd.mul1     = (state_q == iprc_pkg::ST_MUL1);
		cmd.mul2     = (state_q == iprc_pkg::ST_MUL2);
		cmd.acc      = (state_q == iprc_pkg::ST_ACC);
		cmd.dset     = (state_q == iprc_pkg::ST_DSET);
		cmd.div_step = (state_q == iprc_pkg::ST_DIV);
		cmd.clamp    = (state_q == iprc_pkg::ST_CLAMP);
		cmd.commit   = (state_q == iprc_pkg::ST_COMMIT);
		cmd.out_load = deliver;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iprc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == iprc_pkg::ST_DIV) begin
				cnt_q <= div_last ? '0 : cnt_q + 1'b1;
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/iprc_dp.sv
// ----------------------------------------------------------------------------
// iprc_dp - datapath of the incremental PI regulator
// Configuration registers, error and increment arithmetic, saturating
// command accumulator, radix-4 restoring divider and output clamp.
// ----------------------------------------------------------------------------
module iprc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iprc_pkg::iprc_cmd_t                 cmd,
	input  logic                                cfg_we,
	input  logic [iprc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data,
	input  logic signed [15:0]                  setpoint,
	input  logic signed [23:0]                  measurement,
	output logic signed [15:0]                  drive,
	output logic [1:0]                          clamped
);

	// configuration
	logic [15:0]        kp_q, ti_q;
	logic signed [15:0] out_min_q, out_max_q;
	logic [15:0]        t;

	// sample and intermediate registers
	logic signed [15:0] sp_q;
	logic signed [23:0] meas_q;
	logic [55:0]        prod_q;
	logic               neg10_q;
	logic signed [24:0] e_q, prev_q;
	logic signed [25:0] delta_q;
	logic signed [43:0] s_q;
	logic signed [60:0] inc_q;
	logic signed [63:0] cmd_q;
	logic [47:0]        num_q;
	logic [15:0]        rem_q;
	logic               qneg_q;
	logic signed [15:0] res_drive_q;
	logic [1:0]         res_flag_q;
	logic signed [15:0] drive_q;
	logic [1:0]         clamped_q;

	// combinational terms
	logic signed [23:0] x_scaled;
	logic [23:0]        x_mag;
	logic [55:0]        prod_d;
	logic signed [21:0] q10;
	logic signed [24:0] e_d;
	logic signed [25:0] delta_d;
	logic signed [42:0] tprod;
	logic signed [43:0] s_d;
	logic signed [60:0] inc_d;
	logic signed [63:0] inc_ext, sum;
	logic               ovf;
	logic [63:0]        cmd_mag;
	logic [47:0]        num_d;
	logic [15:0]        rem_d;
	logic [16:0]        trial;
	logic signed [48:0] quot;
	logic signed [48:0] lo_ext, hi_ext;
	logic signed [32:0] lim_prod;

	assign t = (ti_q == 16'd0) ? 16'd1 : ti_q;

	// setpoint * 256 / 10, truncated toward zero via magnitude
	assign x_scaled = {sp_q, 8'h00};
	assign x_mag    = x_scaled[23] ? 24'(-x_scaled) : 24'(x_scaled);
	assign prod_d   = 56'(x_mag) * 56'(iprc_pkg::RECIP10);
	assign q10      = neg10_q ? -$signed({1'b0, prod_q[55:iprc_pkg::RECIP10_SHIFT]})
	                          :  $signed({1'b0, prod_q[55:iprc_pkg::RECIP10_SHIFT]});
	assign e_d      = 25'(q10) - 25'(meas_q);
	assign delta_d  = 26'(e_d) - 26'(prev_q);

	assign tprod = $signed({1'b0, t}) * delta_q;
	assign s_d   = (44'(e_q) <<< 8) + 44'(tprod);
	assign inc_d = $signed({1'b0, kp_q}) * s_q;

	// saturating 64-bit add
	assign inc_ext = 64'(inc_q);
	assign sum     = cmd_q + inc_ext;
	assign ovf     = (cmd_q[63] == inc_ext[63]) && (sum[63] != cmd_q[63]);

	assign cmd_mag = cmd_q[63] ? 64'(-cmd_q) : 64'(cmd_q);

	// two restoring steps per cycle
	always_comb begin
		num_d = num_q;
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < iprc_pkg::DIV_RADIX; i++) begin
			trial = {rem_d, num_d[47]};
			if (trial >= {1'b0, t}) begin
				rem_d = 16'(trial - {1'b0, t});
				num_d = {num_d[46:0], 1'b1};
			end else begin
				rem_d = trial[15:0];
				num_d = {num_d[46:0], 1'b0};
			end
		end
	end

	assign quot     = qneg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign lo_ext   = 49'(out_min_q);
	assign hi_ext   = 49'(out_max_q);
	assign lim_prod = res_drive_q * $signed({1'b0, t});

	// configuration and state that the model clears at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= iprc_pkg::KP_RESET;
			ti_q      <= iprc_pkg::TI_RESET;
			out_min_q <= iprc_pkg::OUT_MIN_RESET;
			out_max_q <= iprc_pkg::OUT_MAX_RESET;
			prev_q    <= '0;
			cmd_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					iprc_pkg::REG_KP:      kp_q      <= cfg_data;
					iprc_pkg::REG_TI:      ti_q      <= cfg_data;
					iprc_pkg::REG_OUT_MIN: out_min_q <= cfg_data;
					iprc_pkg::REG_OUT_MAX: out_max_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc) begin
				if (ovf) begin
					cmd_q <= cmd_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					cmd_q <= sum;
				end
			end
			if (cmd.commit) begin
				prev_q <= e_q;
				if (res_flag_q != iprc_pkg::CLAMP_NONE) begin
					cmd_q <= {{15{lim_prod[32]}}, lim_prod, 16'h0000};
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sp_q   <= setpoint;
			meas_q <= measurement;
		end
		if (cmd.scale) begin
			prod_q  <= prod_d;
			neg10_q <= x_scaled[23];
		end
		if (cmd.err) begin
			e_q     <= e_d;
			delta_q <= delta_d;
		end
		if (cmd.mul1) begin
			s_q <= s_d;
		end
		if (cmd.mul2) begin
			inc_q <= inc_d;
		end
		if (cmd.dset) begin
			num_q  <= cmd_mag[63:16];
			rem_q  <= '0;
			qneg_q <= cmd_q[63];
		end
		if (cmd.div_step) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
		if (cmd.clamp) begin
			if (quot < lo_ext) begin
				res_drive_q <= out_min_q;
				res_flag_q  <= iprc_pkg::CLAMP_LOW;
			end else if (quot > hi_ext) begin
				res_drive_q <= out_max_q;
				res_flag_q  <= iprc_pkg::CLAMP_HIGH;
			end else begin
				res_drive_q <= quot[15:0];
				res_flag_q  <= iprc_pkg::CLAMP_NONE;
			end
		end
		if (cmd.out_load) begin
			drive_q   <= res_drive_q;
			clamped_q <= res_flag_q;
		end
	end

	assign drive   = drive_q;
	assign clamped = clamped_q;

endmodule

FILE: hw/rtl/incremental_pi_current_regulator_core.sv
// ----------------------------------------------------------------------------
// incremental_pi_current_regulator_core - velocity form PI regulator
// Per sample: e = setpoint/10 - measurement (Q.8), command += kp*(e*256 +
// ti*(e - last e)) saturating in Q.24, drive = command/(ti*2^16) clamped to
// [out_min, out_max] with the command reloaded from the limit on a clamp.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | beat taken when
//  --------+----------------------------------+-----------------------------
//  in      | setpoint, measurement            | in_valid  && in_ready
//  out     | drive, clamped                   | out_valid && out_ready
//  cfg     | cfg_we, cfg_index, cfg_data      | cfg_we (no wait, no read-back)
//
//  A result passes through the scale, error, two multiply, accumulate,
//  divider set-up, divide, clamp, commit and finish steps; the divider
//  retires two quotient bits a cycle of the 48-bit command/ti division.
//  A new input beat is taken only once the last result has reached the output register.
//  A finished result sits in the output register, so the next input beat is
//  taken while it waits; a stalled output holds the sequencer in its last step.
//  Reset loads kp = ti = 1.0, the full drive range and clears the error and
//  command state; it needs no clearing pass.
//
module incremental_pi_current_regulator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  setpoint,
	input  logic signed [23:0]                  measurement,
	// result output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  drive,
	output logic [1:0]                          clamped,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [iprc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data
);

	// command bundle from sequencer to datapath
	iprc_pkg::iprc_cmd_t cmd;

	// sequencer: walk each sample through the steps, own both handshakes
	iprc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: hold configuration, advance the command, divide and clamp
	iprc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.setpoint    (setpoint),
		.measurement (measurement),
		.drive       (drive),
		.clamped     (clamped)
	);

endmodule

FILE: hw/rtl/iprc_checker.sv
// ----------------------------------------------------------------------------
// iprc_checker - port-level checks of the incremental PI regulator
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module iprc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [15:0]                  setpoint,
	input  logic signed [23:0]                  measurement,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [15:0]                  drive,
	input  logic [1:0]                          clamped,
	input  logic                                cfg_we,
	input  logic [iprc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
		else $error("result beat changed while stalled");

	// the clamp code never takes the unused value
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clamped != 2'd3)
		else $error("invalid clamp code");

	// one sample at a time: busy right after an input beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	// a new result appears exactly as the sequencer returns to idle
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result loaded while still busy");

endmodule

bind incremental_pi_current_regulator_core iprc_checker u_iprc_checker (.*);

FILE: tb/incremental_pi_current_regulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// incremental_pi_current_regulator_core_tb - self-checking regression
// Drives sample beats into the regulator and mirrors the PI arithmetic in a
// cycle-free software regulator. Each drive beat is checked against the
// oldest prediction. Register settings change only while the core is idle.
// Both channels idle and stall at random, with stretches of back-pressure.
// ----------------------------------------------------------------------------
module incremental_pi_current_regulator_core_tb;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 40;       // a little above the sample-to-result latency
	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_GAP       = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTINGS_PER_PHASE = 6;
	localparam int SAMPLES_PER_SETTING = 64;

	// indexes past the last register: the core must ignore writes to them
	localparam logic [iprc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = iprc_pkg::REG_OUT_MAX + 1'b1;
	localparam logic [iprc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	localparam longint CMD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint CMD_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [15:0] drive;
		logic [1:0]         clamped;
	} drive_beat_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [15:0]                  setpoint = '0;
	logic signed [23:0]                  measurement = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [15:0]                  drive;
	logic [1:0]                          clamped;
	logic                                cfg_we = 1'b0;
	logic [iprc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [15:0]                         cfg_data = '0;

	// software copy of the regulator: registers and loop state
	logic [15:0]               gain_kp  = iprc_pkg::KP_RESET;
	logic [15:0]               gain_ti  = iprc_pkg::TI_RESET;
	logic signed [15:0]        limit_lo = iprc_pkg::OUT_MIN_RESET;
	logic signed [15:0]        limit_hi = iprc_pkg::OUT_MAX_RESET;
	longint                    last_error = 0;
	longint                    command_q24 = 0;

	drive_beat_t               pending_drives[$];
	int                        mismatch_count = 0;
	int                        cycle_count = 0;
	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;
	int                        hold_request = 0;
	int                        hold_left = 0;

	incremental_pi_current_regulator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.setpoint   (setpoint),
		.measurement(measurement),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.clamped    (clamped),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run one sample through the software regulator and advance its state.
	// Error in Q.8, increment in Q.24, command saturates at 64 bits, drive is
	// the command over ti*2^16 truncated toward zero, then clamped low first.
	function automatic drive_beat_t regulate_sample(input logic signed [15:0] sp,
			input logic signed [23:0] meas);
		longint      sp_l, meas_l, kp_l, t, e, s, inc, sum, div, q, lo, hi, next_cmd;
		drive_beat_t beat;
		sp_l   = sp;
		meas_l = meas;
		kp_l   = gain_kp;
		t      = gain_ti;
		if (t == 0)
			t = 1;          // a zero ti behaves as one
		lo = limit_lo;
		hi = limit_hi;
		e   = (sp_l * 256) / 10 - meas_l;
		s   = e * 256 + t * (e - last_error);
		inc = kp_l * s;
		sum = command_q24 + inc;
		if (command_q24[63] == inc[63] && sum[63] != inc[63])
			sum = inc[63] ? CMD_MIN : CMD_MAX;
		div = t * 65536;
		q   = sum / div;
		if (q < lo) begin
			beat.drive   = limit_lo;
			beat.clamped = iprc_pkg::CLAMP_LOW;
			next_cmd     = lo * div;
		end else if (q > hi) begin
			beat.drive   = limit_hi;
			beat.clamped = iprc_pkg::CLAMP_HIGH;
			next_cmd     = hi * div;
		end else begin
			beat.drive   = q[15:0];
			beat.clamped = iprc_pkg::CLAMP_NONE;
			next_cmd     = sum;
		end
		last_error  = e;
		command_q24 = next_cmd;
		return beat;
	endfunction

	// Offer one sample beat. Entered and left at a falling edge; valid is left
	// high so that a back-to-back beat never drops it for a moment.
	task automatic send_sample(input logic signed [15:0] sp, input logic signed [23:0] meas);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		setpoint    <= sp;
		measurement <= meas;
		do
			@(posedge clk);
		while (!in_ready);
		pending_drives.push_back(regulate_sample(sp, meas));
		@(negedge clk);
	endtask

	// Drop valid, wait for every outstanding drive beat, then let the core settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write; mirror it in the software regulator.
	task automatic write_register(input logic [iprc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			iprc_pkg::REG_KP:      gain_kp  = value;
			iprc_pkg::REG_TI:      gain_ti  = value;
			iprc_pkg::REG_OUT_MIN: limit_lo = value;
			iprc_pkg::REG_OUT_MAX: limit_hi = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] kp, input logic [15:0] ti,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		write_register(iprc_pkg::REG_KP, kp);
		write_register(iprc_pkg::REG_TI, ti);
		write_register(iprc_pkg::REG_OUT_MIN, lo);
		write_register(iprc_pkg::REG_OUT_MAX, hi);
	endtask

	// Draw a register setting, leaning on the corners of each register.
	task automatic pick_settings();
		int          pick, a, b;
		logic [15:0] kp, ti;
		logic signed [15:0] lo, hi;
		pick = $urandom_range(99);
		if (pick < 15)       kp = '0;
		else if (pick < 30)  kp = '1;
		else if (pick < 50)  kp = 16'($urandom_range(64, 1));
		else if (pick < 75)  kp = 16'($urandom_range(512, 64));
		else                 kp = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 20)       ti = '0;
		else if (pick < 35)  ti = 16'd1;
		else if (pick < 50)  ti = '1;
		else                 ti = 16'($urandom);
		pick = $urandom_range(99);
		a = int'($urandom_range(8192)) - 4096;
		b = int'($urandom_range(8192)) - 4096;
		if (pick < 30) begin
			lo = iprc_pkg::OUT_MIN_RESET;
			hi = iprc_pkg::OUT_MAX_RESET;
		end else if (pick < 70) begin
			lo = 16'((a < b) ? a : b);
			hi = 16'((a < b) ? b : a);
		end else if (pick < 85) begin
			// crossed limits
			lo = 16'($urandom_range(4096, 1));
			hi = -16'($urandom_range(4096, 1));
		end else begin
			lo = 16'($urandom);
			hi = 16'($urandom);
		end
		write_all(kp, ti, lo, hi);
		if ($urandom_range(99) < 20)
			write_register(iprc_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
				16'($urandom));
	endtask

	// Draw a sample: mostly tracking the setpoint closely so the drive moves
	// within its limits, the rest raw noise and field corners.
	task automatic pick_sample(output logic signed [15:0] sp, output logic signed [23:0] meas);
		int kind, target, span, noise;
		kind = $urandom_range(99);
		sp   = 16'($urandom);
		if (kind < 55) begin
			case ($urandom_range(2))
				0:       span = 16;
				1:       span = 256;
				default: span = 4096;
			endcase
			target = (int'(sp) * 256) / 10;
			noise  = int'($urandom_range(2 * span)) - span;
			meas   = 24'(target + noise);
		end else if (kind < 80) begin
			meas = 24'($urandom);
		end else begin
			case ($urandom_range(3))
				0:       sp = 16'sh7FFF;
				1:       sp = 16'sh8000;
				2:       sp = '0;
				default: sp = '1;
			endcase
			case ($urandom_range(3))
				0:       meas = 24'sh7F_FFFF;
				1:       meas = 24'sh80_0000;
				2:       meas = '0;
				default: meas = '1;
			endcase
		end
	endtask

	// ---- tests ---------------------------------------------------------------

	// Reset values: unit gain, full range; includes negative setpoint rounding.
	task automatic test_reset_defaults();
		send_sample(16'sd0, 24'sd0);
		send_sample(16'sd10, 24'sd256);
		send_sample(-16'sd1, 24'sd0);
		send_sample(16'sd7, 24'sd0);
		send_sample(-16'sd7, 24'sd0);
		drain_results();
	endtask

	// Field extremes: drive both clamps from the full input range.
	task automatic test_field_extremes();
		send_sample(16'sh7FFF, 24'sh80_0000);
		send_sample(16'sh8000, 24'sh7F_FFFF);
		send_sample(16'sh8000, 24'sh80_0000);
		send_sample(16'sh7FFF, 24'sh7F_FFFF);
		send_sample(16'sd0, -24'sd1);
		send_sample(-16'sd1, 24'sd0);
		drain_results();
	endtask

	// Register corners: zero ti, crossed and equal limits, zero gain, spare
	// indexes that must leave every register alone.
	task automatic test_register_corners();
		write_all('1, '0, iprc_pkg::OUT_MIN_RESET, iprc_pkg::OUT_MAX_RESET);
		send_sample(16'sd20, 24'sd0);
		send_sample(-16'sd20, 24'sd0);
		drain_results();
		write_all(16'd256, 16'd256, 16'sh7FFF, 16'sh8000);
		send_sample(16'sd0, 24'sd0);
		send_sample(16'sh7FFF, 24'sh80_0000);
		drain_results();
		write_all(16'd300, 16'd1, 16'sd5, 16'sd5);
		send_sample(16'sd100, 24'sd0);
		send_sample(-16'sd100, 24'sd0);
		drain_results();
		write_register(iprc_pkg::REG_KP, '0);
		send_sample(16'sh7FFF, 24'sh80_0000);
		send_sample(16'sh8000, 24'sh7F_FFFF);
		drain_results();
		for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
			write_register(iprc_pkg::CFG_IDX_W'(i), (i % 2 != 0) ? 16'hFFFF : 16'h0000);
		send_sample(16'sd40, 24'sd0);
		send_sample(-16'sd40, 24'sd0);
		drain_results();
		write_all('1, 16'd1, iprc_pkg::OUT_MIN_RESET, iprc_pkg::OUT_MAX_RESET);
		send_sample(16'sd1, 24'sd0);
		send_sample(-16'sd1, 24'sd1);
		drain_results();
	endtask

	// Random traffic over several register settings at one idling mix.
	task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
		logic signed [15:0] sp;
		logic signed [23:0] meas;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
			pick_settings();
			for (int n = 0; n < SAMPLES_PER_SETTING; n++) begin
				pick_sample(sp, meas);
				send_sample(sp, meas);
			end
			drain_results();
		end
	endtask

	// Back-pressure: hold the result side off for a long stretch while beats
	// keep coming, so the core fills and stalls its input; then pause the
	// sender until everything is back before resuming.
	task automatic test_flow_control();
		logic signed [15:0] sp;
		logic signed [23:0] meas;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all(16'd256, 16'd256, -16'sd2000, 16'sd2000);
		@(posedge clk);
		hold_request = HOLD_CYCLES;
		@(negedge clk);
		for (int n = 0; n < 16; n++) begin
			pick_sample(sp, meas);
			send_sample(sp, meas);
		end
		drain_results();
		for (int n = 0; n < 8; n++) begin
			pick_sample(sp, meas);
			send_sample(sp, meas);
		end
		drain_results();
	endtask

	// ---- result side -----------------------------------------------------------

	// Drive ready at the falling edge; a hold request stalls it outright.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each drive beat against the oldest prediction.
	always @(posedge clk) begin
		drive_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				$error("drive beat with nothing expected: drive %0d clamped %0d",
					drive, clamped);
				mismatch_count++;
			end else begin
				want = pending_drives.pop_front();
				if (drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, drive);
					mismatch_count++;
				end
				if (clamped !== want.clamped) begin
					$error("clamped: expected %0d, got %0d", want.clamped, clamped);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: count cycles and abandon a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("incremental_pi_current_regulator_core regression: fail");
			$finish;
		end
	end

	// ---- sequence --------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_register_corners();
		test_random_traffic(26, 74);
		test_random_traffic(74, 26);
		test_random_traffic(0, 0);
		test_flow_control();
		drain_results();
		if (mismatch_count == 0 && pending_drives.size() == 0)
			$display("incremental_pi_current_regulator_core regression: pass");
		else
			$display("incremental_pi_current_regulator_core regression: fail");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/iprc_pkg.sv
hw/rtl/iprc_ctrl.sv
hw/rtl/iprc_dp.sv
hw/rtl/incremental_pi_current_regulator_core.sv
hw/rtl/iprc_checker.sv
tb/incremental_pi_current_regulator_core_tb.sv
